// ===== rtl/hcbd_pkg.sv =====
// Shared types, constants and helpers of the HTTP chunked body decoder.
// No dependencies; imported by hcbd_step and http_chunked_body_decoder.
`default_nettype none

package hcbd_pkg;

   // Size line limit (characters before CR LF, exclusive) and counter width.
   localparam int MAX_LINE_CHARS = 32;
   localparam int LENGTH_BITS    = 24;
   localparam int LINE_W         = $clog2(MAX_LINE_CHARS + 2);
   localparam int SIZE_W         = LENGTH_BITS + 1;

   // Fixed port widths.
   localparam int CFG_W     = 24;
   localparam int OUT_LEN_W = 24;
   localparam int BYTE_W    = 8;

   localparam logic [CFG_W-1:0] DEFAULT_MAX_BYTES = CFG_W'(5 * 1024 * 1024);

   localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;
   localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;

   typedef enum logic [2:0] {
      PHASE_SIZE    = 3'd0,
      PHASE_SIZE_LF = 3'd1,
      PHASE_EXT     = 3'd2,
      PHASE_DATA    = 3'd3,
      PHASE_DATA_CR = 3'd4,
      PHASE_DATA_LF = 3'd5,
      PHASE_DONE    = 3'd6,
      PHASE_FAIL    = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ST_BUSY      = 2'd0,
      ST_DONE      = 2'd1,
      ST_MALFORMED = 2'd2
   } status_type;

   typedef struct packed {
      phase_type               phase;
      logic                    cr_inside_extension;
      logic [LINE_W-1:0]       line_chars;
      logic                    digit_seen;
      logic [SIZE_W-1:0]       size_value;
      logic [LENGTH_BITS-1:0]  chunk_left;
      logic [LENGTH_BITS-1:0]  decoded_count;
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    out_byte;
      logic                 out_valid;
      status_type           status;
      logic [OUT_LEN_W-1:0] decoded_length;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   localparam state_type STATE_RESTART = '{
      phase:               PHASE_SIZE,
      cr_inside_extension: 1'b0,
      line_chars:          '0,
      digit_seen:          1'b0,
      size_value:          '0,
      chunk_left:          '0,
      decoded_count:       '0
   };

   // Hex digit of either case.
   function automatic hex_type hex_decode(input logic [BYTE_W-1:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      priority if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/hcbd_step.sv =====
// Next-state and result logic of the chunked body decoder for one byte.
// Purely combinational; depends on hcbd_pkg.
`default_nettype none

module hcbd_step (
   input  wire hcbd_pkg::state_type             cur_state,
   input  wire logic [hcbd_pkg::CFG_W-1:0]      max_bytes,
   input  wire logic [hcbd_pkg::BYTE_W-1:0]     in_byte,
   input  wire logic                            first_byte,
   input  wire logic                            last_byte,
   output hcbd_pkg::state_type                  next_state,
   output hcbd_pkg::result_type                 result
);
   import hcbd_pkg::*;

   state_type              s;
   state_type              n;
   hex_type                hex;
   logic [LINE_W-1:0]      lc_inc;
   logic [LINE_W-1:0]      lc_ext;
   logic [LINE_W-1:0]      lc_ext_inc;
   logic [LENGTH_BITS-1:0] limit;
   logic [LENGTH_BITS:0]   headroom;
   logic                   size_ovf;
   logic [SIZE_W-1:0]      size_acc;
   phase_type              line_phase;
   logic                   is_cr;
   logic                   is_lf;

   always_comb begin
      s = first_byte ? STATE_RESTART : cur_state;
   end

   // Size line close: zero size ends the body, else check the total limit.
   always_comb begin
      limit    = LENGTH_BITS'(max_bytes);
      headroom = {1'b0, limit} - {1'b0, s.decoded_count};
      priority if (s.size_value == '0) begin
         line_phase = PHASE_DONE;
      end else if (s.decoded_count > limit
                   || s.size_value > SIZE_W'(headroom)) begin
         line_phase = PHASE_FAIL;
      end else begin
         line_phase = PHASE_DATA;
      end
   end

   // Saturating hex accumulate.
   always_comb begin
      hex      = hex_decode(in_byte);
      size_ovf = |s.size_value[SIZE_W-1 -: 4];
      size_acc = size_ovf ? '1 : {s.size_value[SIZE_W-5:0], hex.value};
   end

   always_comb begin
      is_cr      = (in_byte == CHAR_CR);
      is_lf      = (in_byte == CHAR_LF);
      lc_inc     = s.line_chars + LINE_W'(1);
      // a CR in an extension not followed by LF counts as a character
      lc_ext     = s.line_chars + LINE_W'(s.cr_inside_extension);
      lc_ext_inc = lc_ext + LINE_W'(1);
      n          = s;

      unique case (s.phase)
         PHASE_SIZE: begin
            priority if (hex.ok) begin
               n.size_value = size_acc;
               n.digit_seen = 1'b1;
               n.line_chars = lc_inc;
               if (lc_inc >= LINE_W'(MAX_LINE_CHARS)) n.phase = PHASE_FAIL;
            end else if (is_cr) begin
               n.phase = PHASE_SIZE_LF;
            end else if ((in_byte == CHAR_SEMI || in_byte == CHAR_NUL)
                         && s.digit_seen) begin
               n.line_chars = lc_inc;
               n.phase = (lc_inc >= LINE_W'(MAX_LINE_CHARS)) ? PHASE_FAIL : PHASE_EXT;
            end else begin
               n.phase = PHASE_FAIL;
            end
         end
         PHASE_SIZE_LF: begin
            if (is_lf && s.digit_seen) begin
               n.phase               = line_phase;
               n.line_chars          = '0;
               n.cr_inside_extension = 1'b0;
               n.digit_seen          = 1'b0;
               n.size_value          = '0;
               n.chunk_left          = s.size_value[LENGTH_BITS-1:0];
            end else begin
               n.phase = PHASE_FAIL;
            end
         end
         PHASE_EXT: begin
            priority if (s.cr_inside_extension && is_lf) begin
               n.phase               = line_phase;
               n.line_chars          = '0;
               n.cr_inside_extension = 1'b0;
               n.digit_seen          = 1'b0;
               n.size_value          = '0;
               n.chunk_left          = s.size_value[LENGTH_BITS-1:0];
            end else if (s.cr_inside_extension
                         && lc_ext >= LINE_W'(MAX_LINE_CHARS)) begin
               n.cr_inside_extension = 1'b0;
               n.line_chars          = lc_ext;
               n.phase               = PHASE_FAIL;
            end else if (is_cr) begin
               n.cr_inside_extension = 1'b1;
               n.line_chars          = lc_ext;
            end else begin
               n.cr_inside_extension = 1'b0;
               n.line_chars          = lc_ext_inc;
               if (lc_ext_inc >= LINE_W'(MAX_LINE_CHARS)) n.phase = PHASE_FAIL;
            end
         end
         PHASE_DATA: begin
            n.decoded_count = s.decoded_count + LENGTH_BITS'(1);
            n.chunk_left    = s.chunk_left - LENGTH_BITS'(1);
            if (s.chunk_left == LENGTH_BITS'(1)) n.phase = PHASE_DATA_CR;
         end
         PHASE_DATA_CR: n.phase = is_cr ? PHASE_DATA_LF : PHASE_FAIL;
         PHASE_DATA_LF: n.phase = is_lf ? PHASE_SIZE : PHASE_FAIL;
         PHASE_DONE:    n.phase = PHASE_DONE;
         PHASE_FAIL:    n.phase = PHASE_FAIL;
         default:       n.phase = PHASE_FAIL;
      endcase

      // end of input before the zero chunk
      if (last_byte && n.phase != PHASE_DONE) n.phase = PHASE_FAIL;

      next_state = n;

      result.out_valid      = (s.phase == PHASE_DATA);
      result.out_byte       = (s.phase == PHASE_DATA) ? in_byte : '0;
      result.decoded_length = OUT_LEN_W'(n.decoded_count);
      priority if (n.phase == PHASE_DONE) begin
         result.status = ST_DONE;
      end else if (n.phase == PHASE_FAIL) begin
         result.status = ST_MALFORMED;
      end else begin
         result.status = ST_BUSY;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked transfer-coding body decoder.
// Depends on hcbd_pkg and hcbd_step.
`default_nettype none

// One raw body byte per request beat, one result beat per byte, in order.
// A byte is decoded in the cycle it is accepted and its registered result
// appears on the rsp_ side in the next cycle; the decoder sustains one byte
// per clock unless rsp_stall holds a result. req_stall rises only while
// a result is held on rsp_ under rsp_stall. req_first_byte restarts the
// decoder for a new body; req_last_byte on a body that has not reached its
// zero-size chunk marks it malformed. Payload bytes (rsp_out_valid high)
// stream out before the outcome is known: once rsp_status reads malformed
// (2) the consumer discards that body's payload; completed (1) means the
// zero chunk was seen and later bytes are ignored. csr_wr_data sets the
// largest payload total allowed per body (reset 5 MiB); write it only while
// the decoder is idle. A new limit takes effect at the next size line.
module http_chunked_body_decoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_wr_en,
   input  wire logic [hcbd_pkg::CFG_W-1:0]          csr_wr_data,
   // body byte beats
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [hcbd_pkg::BYTE_W-1:0]         req_in_byte,
   input  wire logic                                req_first_byte,
   input  wire logic                                req_last_byte,
   // result beats
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [hcbd_pkg::BYTE_W-1:0]              rsp_out_byte,
   output logic                                     rsp_out_valid,
   output logic [1:0]                               rsp_status,
   output logic [hcbd_pkg::OUT_LEN_W-1:0]           rsp_decoded_length
);
   import hcbd_pkg::*;

   logic [CFG_W-1:0] max_bytes_ff;
   state_type        state_ff;
   state_type        state_in;
   result_type       result_in;
   result_type       result_ff;
   logic             rsp_valid_ff;
   logic             req_accept;

   // Output register frees up whenever its beat is taken.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   hcbd_step u_step (
      .cur_state  (state_ff),
      .max_bytes  (max_bytes_ff),
      .in_byte    (req_in_byte),
      .first_byte (req_first_byte),
      .last_byte  (req_last_byte),
      .next_state (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= DEFAULT_MAX_BYTES;
      end else if (csr_wr_en) begin
         max_bytes_ff <= csr_wr_data;
      end
   end

   // Parser state advances only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESTART;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         rsp_valid_ff <= req_valid;
      end
   end

   // Result payload, no reset needed.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = result_ff.out_byte;
   assign rsp_out_valid      = result_ff.out_valid;
   assign rsp_status         = result_ff.status;
   assign rsp_decoded_length = result_ff.decoded_length;

endmodule

`default_nettype wire
